/* design/mf2d_pkg.sv */
// shared constants, types and the median network of the 3x3 gray median filter
`timescale 1ns / 1ps
`default_nettype none

package mf2d_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    // rows run two past the frame while the last results drain
    localparam int ROW_W      = 13;
    localparam int NUM_BANKS  = 3;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int DRAIN_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIN_N      = 9;
    localparam int WIN_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

    typedef logic [BANK_W-1:0] bank_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

    // what one window step carries from issue to the median stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        bank_t            sel_up1;
        bank_t            sel_up2;
        logic             produce;
        logic             last;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
    } step_t;

    // compare and exchange: smaller value ends at position a
    function automatic win_t cswap(input win_t p, input logic [WIN_IDX_W-1:0] a,
                                   input logic [WIN_IDX_W-1:0] b);
        win_t q;
        q = p;
        if (p[a] > p[b]) begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

    // 19 exchange median-of-nine network
    function automatic logic [PIX_W-1:0] median9(input win_t w);
        win_t p;
        p = w;
        p = cswap(p, 4'd1, 4'd2); p = cswap(p, 4'd4, 4'd5); p = cswap(p, 4'd7, 4'd8);
        p = cswap(p, 4'd0, 4'd1); p = cswap(p, 4'd3, 4'd4); p = cswap(p, 4'd6, 4'd7);
        p = cswap(p, 4'd1, 4'd2); p = cswap(p, 4'd4, 4'd5); p = cswap(p, 4'd7, 4'd8);
        p = cswap(p, 4'd0, 4'd3); p = cswap(p, 4'd5, 4'd8); p = cswap(p, 4'd4, 4'd7);
        p = cswap(p, 4'd3, 4'd6); p = cswap(p, 4'd1, 4'd4); p = cswap(p, 4'd2, 4'd5);
        p = cswap(p, 4'd4, 4'd7); p = cswap(p, 4'd4, 4'd2); p = cswap(p, 4'd6, 4'd4);
        p = cswap(p, 4'd4, 4'd2);
        return p[4];
    endfunction

endpackage

`default_nettype wire

/* design/mf2d_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mf2d_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/median_filter_2d_gray.sv */
// 3x3 median filter for a raster stream of 8-bit gray pixels
//
// usage: set image_width (index 0) and image_height (index 1) on the cfg channel while
// the block is idle; a write to either restarts the frame. pixels enter on the s_ stream in
// raster order with s_tuser = 0; s_tuser = 1 marks a drain item. each result on the m_
// stream is the median of the in-image part of the 3x3 neighborhood, element
// floor(n/2) of the n sorted values, in raster order, m_tlast on the frame's last one.
// the result for pixel k goes with the item that brings pixel k + width + 1; the
// results still owed at frame end go with drain items, one each: width + 1 of them, or
// width - 1 in a one-row frame, one in a 1 x 2 frame. throughput: one pixel item per
// cycle while the output queue has room, set by the single window shift per step and the
// one write plus one read per line bank and cycle. after a drain item s_tready is low
// until its virtual step issues. the line store is three banks of 1024 pixels, one per
// row in rotation; data is used only where written this frame and needs no clearing pass.
// reset (aresetn low, synchronous) restores 640 x 480 and empties the pipeline.
// when m_tready is low the two-entry output queue fills and s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_2d_gray
    import mf2d_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_value
    input  wire logic [0:0]            s_tuser,   // [0] command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [PIX_W-1:0]      m_tdata,   // [7:0] median_value
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [WID_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic [WID_W-1:0] w_eff, w_m1;
    logic [HGT_W-1:0] h_eff, h_m1, h_p1;
    logic [COL_W-1:0] w_last_col;
    logic             cfg_wr, cfg_restart;

    // step position, rows past the frame are drain steps
    logic [COL_W-1:0]   pos_col_reg, pos_col_next;
    logic [ROW_W-1:0]   pos_row_reg, pos_row_next;
    bank_t              bank_reg, bank_next;
    logic               credit_reg, credit_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic [DRAIN_W-1:0] drain_init;

    logic virt, wrap_col, last_step, done_item, warm;
    logic s_acc, is_data, drain_active, data_step, v_fire, step_fire;
    logic model_emit, consume;

    // median stage
    logic  b_valid_reg, b_valid_next;
    step_t b_info_reg, b_info_next;
    logic  b_adv, a_free, push, pop, fifo_full;

    logic [PIX_W-1:0] rd_data [NUM_BANKS];
    logic [PIX_W-1:0] left_reg [3];
    logic [PIX_W-1:0] mid_reg [3];
    logic [PIX_W-1:0] new_col [3];
    win_t             win;
    logic [1:0]       nr, nc;
    logic [3:0]       n_valid;
    logic [2:0]       pad_lo;
    logic [PIX_W-1:0] med;

    // output queue
    logic [1:0]       cnt_reg, cnt_next;
    logic [PIX_W:0]   q0_reg, q0_next, q1_reg, q1_next;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_restart = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_next  = cfg_data[WID_W-1:0];
                    cfg_restart = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = cfg_data[HGT_W-1:0];
                    cfg_restart = 1'b1;
                end
                default: begin
                    width_next  = width_reg;
                end
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WID_W'(1);
        end else if (width_reg > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = HGT_W'(1);
        end else if (height_reg > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign w_m1       = w_eff - WID_W'(1);
    assign w_last_col = w_m1[COL_W-1:0];
    assign h_m1       = h_eff - HGT_W'(1);
    assign h_p1       = h_eff + HGT_W'(1);

    // results owed after the frame's last pixel, beyond the one it releases itself
    always_comb begin
        if (h_eff == HGT_W'(1)) begin
            drain_init = w_m1;
        end else if (h_eff == HGT_W'(2) && w_eff == WID_W'(1)) begin
            drain_init = DRAIN_W'(1);
        end else begin
            drain_init = w_eff + WID_W'(1);
        end
    end

    assign virt      = (pos_row_reg >= h_eff);
    assign wrap_col  = (pos_col_reg == w_last_col);
    assign last_step = virt && (pos_row_reg == h_p1) && (pos_col_reg == '0);
    assign done_item = !virt && wrap_col && (pos_row_reg == h_m1);
    // step index at least width + 1: the step completes a window
    assign warm      = (pos_row_reg >= ROW_W'(2))
                    || ((pos_row_reg == ROW_W'(1)) && (pos_col_reg != '0));

    assign fifo_full = (cnt_reg == 2'd2);
    assign b_adv     = b_valid_reg && (!b_info_reg.produce || !fifo_full);
    assign a_free    = !b_valid_reg || b_adv;

    assign s_tready     = !credit_reg && (virt || a_free);
    assign s_acc        = s_tvalid && s_tready;
    assign is_data      = !s_tuser[0];
    assign drain_active = (drain_reg != '0);

    assign data_step  = s_acc && !drain_active && is_data && !virt;
    assign v_fire     = virt && a_free && (!warm || credit_reg);
    assign step_fire  = data_step || v_fire;
    assign model_emit = s_acc && (drain_active || (data_step && (warm || done_item)));
    assign consume    = step_fire && warm;

    always_comb begin
        pos_col_next = pos_col_reg;
        pos_row_next = pos_row_reg;
        bank_next    = bank_reg;
        credit_next  = credit_reg;
        drain_next   = drain_reg;
        if (cfg_restart) begin
            pos_col_next = '0;
            pos_row_next = '0;
            bank_next    = '0;
            credit_next  = 1'b0;
            drain_next   = '0;
        end else begin
            if (step_fire) begin
                if (last_step) begin
                    pos_col_next = '0;
                    pos_row_next = '0;
                    bank_next    = '0;
                end else if (wrap_col) begin
                    pos_col_next = '0;
                    pos_row_next = pos_row_reg + ROW_W'(1);
                    bank_next    = (bank_reg == bank_t'(NUM_BANKS - 1))
                                 ? '0 : bank_reg + bank_t'(1);
                end else begin
                    pos_col_next = pos_col_reg + COL_W'(1);
                end
            end
            if (model_emit && !consume) begin
                credit_next = 1'b1;
            end else if (consume && !model_emit) begin
                credit_next = 1'b0;
            end
            if (s_acc && drain_active) begin
                drain_next = drain_reg - DRAIN_W'(1);
            end else if (data_step && done_item) begin
                drain_next = drain_init;
            end
        end
    end

    // line banks: the current row is written, the two rows above are read
    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        mf2d_ram #(
            .DATA_W(PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .aclk   (aclk),
            .wr_en  (data_step && (bank_reg == bank_t'(g))),
            .wr_addr(pos_col_reg),
            .wr_data(s_tdata),
            .rd_en  (step_fire),
            .rd_addr(pos_col_reg),
            .rd_data(rd_data[g])
        );
    end

    always_comb begin
        b_info_next         = b_info_reg;
        b_info_next.pixel   = s_tdata;
        b_info_next.produce = warm;
        b_info_next.last    = last_step;
        case (bank_reg)
            bank_t'(0): begin
                b_info_next.sel_up1 = bank_t'(2);
                b_info_next.sel_up2 = bank_t'(1);
            end
            bank_t'(1): begin
                b_info_next.sel_up1 = bank_t'(0);
                b_info_next.sel_up2 = bank_t'(2);
            end
            default: begin
                b_info_next.sel_up1 = bank_t'(1);
                b_info_next.sel_up2 = bank_t'(0);
            end
        endcase
        // the window centers one row up and one column left of the step
        if (pos_col_reg != '0) begin
            b_info_next.top    = (pos_row_reg == ROW_W'(1));
            b_info_next.bottom = (pos_row_reg == h_eff);
            b_info_next.left   = (pos_col_reg == COL_W'(1));
            b_info_next.right  = 1'b0;
        end else begin
            b_info_next.top    = (pos_row_reg == ROW_W'(2));
            b_info_next.bottom = (pos_row_reg == h_p1);
            b_info_next.left   = (w_eff == WID_W'(1));
            b_info_next.right  = 1'b1;
        end
        if (step_fire) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    assign new_col[0] = rd_data[b_info_reg.sel_up2];
    assign new_col[1] = rd_data[b_info_reg.sel_up1];
    assign new_col[2] = b_info_reg.pixel;

    assign nr      = 2'd3 - {1'b0, b_info_reg.top} - {1'b0, b_info_reg.bottom};
    assign nc      = 2'd3 - {1'b0, b_info_reg.left} - {1'b0, b_info_reg.right};
    assign n_valid = 4'(nr) * 4'(nc);
    assign pad_lo  = 3'd4 - n_valid[3:1];

    // out-of-image places get low and high pads so the middle lands on floor(n/2)
    always_comb begin
        logic [3:0]       pads;
        logic             skip;
        logic [PIX_W-1:0] v;
        pads = '0;
        win  = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                skip = (r == 0 && b_info_reg.top) || (r == 2 && b_info_reg.bottom)
                    || (c == 0 && b_info_reg.left) || (c == 2 && b_info_reg.right);
                v = (c == 0) ? left_reg[r] : ((c == 1) ? mid_reg[r] : new_col[r]);
                if (skip) begin
                    v    = (pads < {1'b0, pad_lo}) ? '0 : '1;
                    pads = pads + 4'd1;
                end
                win[r * 3 + c] = v;
            end
        end
    end

    assign med = median9(win);

    assign push = b_adv && b_info_reg.produce;
    assign pop  = (cnt_reg != 2'd0) && m_tready;

    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b11: begin
                if (cnt_reg == 2'd2) begin
                    q0_next = q1_reg;
                    q1_next = {b_info_reg.last, med};
                end else begin
                    q0_next = {b_info_reg.last, med};
                end
            end
            2'b10: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0) begin
                    q0_next = {b_info_reg.last, med};
                end else begin
                    q1_next = {b_info_reg.last, med};
                end
            end
            2'b01: begin
                cnt_next = cnt_reg - 2'd1;
                q0_next  = q1_reg;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q0_reg[PIX_W-1:0];
    assign m_tlast  = q0_reg[PIX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pos_col_reg <= '0;
            pos_row_reg <= '0;
            bank_reg    <= '0;
            credit_reg  <= 1'b0;
            drain_reg   <= '0;
            b_valid_reg <= 1'b0;
            cnt_reg     <= 2'd0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            pos_col_reg <= pos_col_next;
            pos_row_reg <= pos_row_next;
            bank_reg    <= bank_next;
            credit_reg  <= credit_next;
            drain_reg   <= drain_next;
            b_valid_reg <= b_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            b_info_reg <= b_info_next;
        end
        if (b_adv) begin
            for (int r = 0; r < 3; r++) begin
                left_reg[r] <= mid_reg[r];
                mid_reg[r]  <= new_col[r];
            end
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire
